>>> hw/rtl/gama_pkg.sv
// Shared types and constants of the gap-aware moving average unit.
// No dependencies; gama_div, gama_core and the top module import this package.
package gama_pkg;

    localparam int TS_BITS   = 48;
    localparam int WIN_BITS  = 5;
    localparam int GAP_BITS  = 32;
    localparam int NUM_CH    = 3;
    localparam int SUPP_BITS = 3;
    localparam int CFG_IDX_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GAP     = 1'b1;

    localparam logic [WIN_BITS-1:0]  WIN_RESET      = 5'd8;
    localparam logic [WIN_BITS-1:0]  MIN_WINDOW     = 5'd2;
    localparam logic [GAP_BITS-1:0]  GAP_RESET      = 32'd1000;
    localparam logic [SUPP_BITS-1:0] SUPPRESS_START = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_LAUNCH,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] window_size;
        logic [GAP_BITS-1:0] max_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic averaged;
        logic gap_flag;
    } res_flags_t;

endpackage

>>> hw/rtl/gama_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module gama_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/gama_div.sv
// Bit-serial signed divider by the window size, truncating toward zero.
// Depends on gama_pkg for the window size width.
module gama_div
    import gama_pkg::*;
#(
    parameter int SUM_BITS = 29,
    parameter int Q_BITS   = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [WIN_BITS-1:0]        divisor,
    output logic                       done,
    output logic [Q_BITS-1:0]          quotient
);

    localparam int CNT_BITS = $clog2(SUM_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(SUM_BITS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [SUM_BITS-1:0] mag_reg;
    logic [WIN_BITS-1:0] rem_reg;
    logic                neg_reg;

    logic [WIN_BITS:0]   rem_shift;
    logic                take;
    logic [WIN_BITS:0]   rem_diff;
    logic [Q_BITS-1:0]   q_low;

    // One quotient bit per cycle; the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    assign rem_shift = {rem_reg, mag_reg[SUM_BITS-1]};
    assign take      = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_BITS-1];
            mag_reg <= dividend[SUM_BITS-1] ? -dividend : dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= take ? rem_diff[WIN_BITS-1:0] : rem_shift[WIN_BITS-1:0];
            mag_reg <= {mag_reg[SUM_BITS-2:0], take};
        end
    end

    assign q_low    = mag_reg[Q_BITS-1:0];
    assign quotient = neg_reg ? -q_low : q_low;
    assign done     = done_reg;

endmodule

>>> hw/rtl/gama_core.sv
// Sequencer, window store, running sums and gap tracking of the averager.
// Depends on gama_pkg, gama_ram and gama_div.
module gama_core
    import gama_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [TS_BITS-1:0]           in_ts,
    input  logic [NUM_CH*SAMPLE_BITS-1:0] in_samples,
    output logic                         out_valid,
    input  logic                         out_ready,
    output res_flags_t                   out_flags,
    output logic [NUM_CH*SAMPLE_BITS-1:0] out_avgs
);

    localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int CMP_BITS = (PTR_BITS + 1 > WIN_BITS) ? PTR_BITS + 1 : WIN_BITS;
    localparam int CH_BITS  = $clog2(NUM_CH);
    localparam logic [CH_BITS-1:0]  LAST_CH = CH_BITS'(NUM_CH - 1);
    localparam logic [CMP_BITS-1:0] DEPTH_C = CMP_BITS'(MAX_WINDOW);

    state_t state_reg, state_next;

    logic [TS_BITS-1:0]     ts_reg;
    logic [TS_BITS-1:0]     last_ts_reg;
    logic [TS_BITS-1:0]     diff_reg;
    logic [WIN_BITS-1:0]    fill_reg;
    logic [PTR_BITS-1:0]    wp_reg;
    logic                   gap_active_reg;
    logic [SUPP_BITS-1:0]   supp_reg;
    logic                   gap_flag_reg;
    logic                   averaged_reg;
    logic [CH_BITS-1:0]     ch_reg;

    logic signed [SAMPLE_BITS-1:0] new_reg [NUM_CH];
    logic signed [SUM_BITS-1:0]    sum_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0]        avg_reg [NUM_CH];

    logic                          ram_we;
    logic [NUM_CH*SAMPLE_BITS-1:0] ram_wdata;
    logic [NUM_CH*SAMPLE_BITS-1:0] ram_rdata;

    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_q;

    logic                   gap_now;
    logic                   full_now;
    logic [CMP_BITS-1:0]    wp_inc;
    logic [SUPP_BITS-1:0]   supp_dec;

    assign full_now = fill_reg >= cfg.window_size;
    assign gap_now  = (fill_reg != '0) &&
                      (diff_reg > {{(TS_BITS-GAP_BITS){1'b0}}, cfg.max_gap_ms});
    assign wp_inc   = CMP_BITS'(wp_reg) + 1'b1;
    assign supp_dec = (supp_reg != '0) ? supp_reg - 1'b1 : supp_reg;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            ram_wdata[i*SAMPLE_BITS +: SAMPLE_BITS] = new_reg[i];
            out_avgs[i*SAMPLE_BITS +: SAMPLE_BITS]  = avg_reg[i];
        end
    end

    gama_ram #(
        .WIDTH (NUM_CH * SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (wp_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    gama_div #(
        .SUM_BITS (SUM_BITS),
        .Q_BITS   (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg[ch_reg]),
        .divisor  (cfg.window_size),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = ST_ADD;
            ST_ADD:    state_next = (full_now && !gap_active_reg) ? ST_LAUNCH : ST_DONE;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT: begin
                if (div_done) begin
                    state_next = (ch_reg == LAST_CH) ? ST_DONE : ST_LAUNCH;
                end
            end
            ST_DONE:   if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        ram_we    = (state_reg == ST_READ);
        div_start = (state_reg == ST_LAUNCH);
        out_valid = (state_reg == ST_DONE);
    end

    assign out_flags.gap_flag = gap_flag_reg;
    assign out_flags.averaged = averaged_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            wp_reg         <= '0;
            last_ts_reg    <= '0;
            gap_active_reg <= 1'b0;
            supp_reg       <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (clear) begin
                fill_reg <= '0;
                wp_reg   <= '0;
                for (int i = 0; i < NUM_CH; i++) begin
                    sum_reg[i] <= '0;
                end
            end else begin
                unique case (state_reg)
                    ST_READ: begin
                        if (gap_now) begin
                            gap_active_reg <= 1'b1;
                            supp_reg       <= SUPPRESS_START;
                        end
                        last_ts_reg <= ts_reg;
                        // The entry being replaced leaves the sum only once the
                        // window has filled up.
                        if (!full_now) begin
                            fill_reg <= fill_reg + 1'b1;
                        end else begin
                            for (int i = 0; i < NUM_CH; i++) begin
                                sum_reg[i] <= sum_reg[i] - SUM_BITS'($signed(
                                    ram_rdata[i*SAMPLE_BITS +: SAMPLE_BITS]));
                            end
                        end
                        if (wp_inc >= CMP_BITS'(cfg.window_size) || wp_inc == DEPTH_C) begin
                            wp_reg <= '0;
                        end else begin
                            wp_reg <= wp_inc[PTR_BITS-1:0];
                        end
                    end
                    ST_ADD: begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            sum_reg[i] <= sum_reg[i] + SUM_BITS'(new_reg[i]);
                        end
                        if (full_now && gap_active_reg) begin
                            supp_reg <= supp_dec;
                            if (supp_dec == '0) begin
                                gap_active_reg <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ts_reg <= in_ts;
                    for (int i = 0; i < NUM_CH; i++) begin
                        new_reg[i] <= in_samples[i*SAMPLE_BITS +: SAMPLE_BITS];
                    end
                end
            end
            ST_READ: begin
                gap_flag_reg <= gap_now;
            end
            ST_ADD: begin
                averaged_reg <= full_now && !gap_active_reg;
                ch_reg       <= '0;
                for (int i = 0; i < NUM_CH; i++) begin
                    avg_reg[i] <= '0;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    avg_reg[ch_reg] <= div_q;
                    ch_reg          <= ch_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Time step since the previous sample, modulo 2^48.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            diff_reg <= in_ts - last_ts_reg;
        end
    end

endmodule

>>> hw/rtl/gap_aware_moving_average_unit.sv
// Gap-aware moving average unit: streams in timestamped power, voltage and
// current samples and returns one result per sample.
//
// The s_ channel takes one sample per transfer; the m_ channel returns one
// result per sample, in order. Window size and gap limit are to be written
// through the cfg_ port only while the unit is idle, which the unit itself
// does not enforce; writing the window size empties the window but keeps the
// gap state. For a sample that gets averages, the three window sums go one
// after another through a bit-serial divider, one quotient bit per cycle.
// One sample is worked on at a time; s_tready comes back once the result
// has moved into the output register.
// A result waits in the output register while m_tready is low; the next
// sample is already taken and worked on meanwhile, and it waits at the end
// of its work until the register frees up.
// Reset (aresetn low, synchronous) empties the window, clears the gap state
// and sets window size 8 and gap limit 1000 ms.
module gap_aware_moving_average_unit
    import gama_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 24,
    localparam int S_TDATA_W  = ((TS_BITS + NUM_CH * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((NUM_CH * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [GAP_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // timestamp_ms, power, voltage, current, zero padding
    input  logic [S_TDATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // avg_power, avg_voltage, avg_current, zero padding
    output logic [M_TDATA_W-1:0]    m_tdata,
    // gap_flag, averaged
    output logic [1:0]              m_tuser
);

    localparam int W_CAP = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;
    localparam logic [WIN_BITS-1:0] W_CAP_L = WIN_BITS'(W_CAP);

    cfg_t                          cfg_reg;
    logic [WIN_BITS-1:0]           win_req;
    logic [WIN_BITS-1:0]           win_clamped;
    logic                          win_write;

    logic                          core_out_valid;
    logic                          core_out_ready;
    res_flags_t                    core_flags;
    logic [NUM_CH*SAMPLE_BITS-1:0] core_avgs;

    logic                          m_valid_reg;
    logic [M_TDATA_W-1:0]          m_tdata_reg;
    logic [1:0]                    m_tuser_reg;

    assign win_req     = cfg_wdata[WIN_BITS-1:0];
    assign win_clamped = (win_req < MIN_WINDOW) ? MIN_WINDOW :
                         (win_req > W_CAP_L)    ? W_CAP_L    : win_req;
    assign win_write   = cfg_wr_en && (cfg_index == REG_WINDOW_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_size <= WIN_RESET;
            cfg_reg.max_gap_ms  <= GAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: cfg_reg.window_size <= win_clamped;
                REG_MAX_GAP:     cfg_reg.max_gap_ms  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    gama_core #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (win_write),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_ts      (s_tdata[TS_BITS-1:0]),
        .in_samples (s_tdata[TS_BITS +: NUM_CH*SAMPLE_BITS]),
        .out_valid  (core_out_valid),
        .out_ready  (core_out_ready),
        .out_flags  (core_flags),
        .out_avgs   (core_avgs)
    );

    // The output register loads whenever it is empty or its transfer completes.
    assign core_out_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_out_ready) begin
            m_valid_reg <= core_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_out_ready && core_out_valid) begin
            m_tdata_reg <= M_TDATA_W'(core_avgs);
            m_tuser_reg <= {core_flags.averaged, core_flags.gap_flag};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
